// ===== rtl/core/etf_pkg.sv =====
// Shared types and constants of the escape-time fractal pixel engine.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package etf_pkg;

   // Screen span in pixels (a power of two) and fraction bits of z and c.
   localparam int unsigned SPAN       = 256;
   localparam int unsigned SPAN_LOG2  = $clog2(SPAN);
   localparam int unsigned FRAC_BITS  = 27;
   localparam int unsigned ZOOM_SHIFT = 56 - FRAC_BITS;
   localparam int unsigned ESC_SHIFT  = 2 * FRAC_BITS + 2;

   // Mapping constants, Q.32 intermediate.
   localparam logic signed [63:0] MAP_X_GAIN          = 64'sd262144;
   localparam logic signed [63:0] MAP_Y_GAIN          = 64'sd229376;
   localparam logic signed [63:0] TWO_POINT_EIGHT_Q32 = 64'sd12025908429;
   localparam logic signed [63:0] ONE_Q32             = 64'sd4294967296;

   // Escape bound on |z|^2, all ones when the format leaves no headroom.
   localparam logic [64:0] ESC_LIMIT =
      (ESC_SHIFT < 64) ? (65'd1 << ESC_SHIFT) : {1'b0, {64{1'b1}}};

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   // Color classes.
   localparam logic [3:0]  COLOR_BLACK  = 4'd0;
   localparam logic [3:0]  COLOR_INSIDE = 4'd10;
   localparam logic [15:0] BLACK_LIMIT  = 16'd5;
   localparam logic [3:0]  DIGIT_LAST   = 4'd9;
   localparam logic [3:0]  PALETTE_LAST = 4'd8;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned CSR_AW      = 5;

   typedef enum logic [2:0] {
      CSR_START_RE = 3'd0,
      CSR_START_IM = 3'd1,
      CSR_SHIFT_X  = 3'd2,
      CSR_SHIFT_Y  = 3'd3,
      CSR_INV_ZOOM = 3'd4,
      CSR_MAX_ITER = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] c_re;
      logic signed [31:0] c_im;
   } point_type;

   typedef struct packed {
      logic signed [31:0] start_re;
      logic signed [31:0] start_im;
      logic [15:0]        max_iter;
   } iter_cfg_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MAP,
      F_MUL_LO,
      F_MUL_HI,
      F_SUM,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_MUL,
      B_STEP,
      B_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/escape_time_fractal_pixel_top.sv =====
// Top level of the escape-time fractal pixel engine: register file and wiring.
// Depends on etf_pkg, etf_front, etf_queue and etf_back.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   request | req_valid/req_stall, col, row       | in
//   result  | rsp_valid/rsp_stall, count, class   | out
//   csr     | psel/penable/pwrite/paddr/pwdata... | in/out
//
// The front end maps a pixel, then runs low product, high product and sum
// once per axis; the back end alternates multiply and step per pass until the
// limit or an escape. Sustained rate is set by that loop; the two-entry point
// queue lets mapping of the next pixels overlap the iteration. A stalled result
// holds in the output register while the back end waits. Reset is synchronous
// and clears all control state and loads the register defaults.
`default_nettype none

module escape_time_fractal_pixel_top import etf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [9:0]        req_col,
   input  logic [9:0]        req_row,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [15:0]       rsp_iter_count,
   output logic [3:0]        rsp_color_class,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic signed [31:0] start_re_ff, start_im_ff, shift_x_ff, shift_y_ff;
   logic [31:0]        inv_zoom_ff;
   logic [15:0]        max_iter_ff;

   logic         csr_write;
   logic [2:0]   csr_index;
   iter_cfg_type iter_cfg;
   point_type    push_data, pop_data;
   logic         push, pop, queue_full, queue_empty;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_re_ff <= '0;
         start_im_ff <= '0;
         shift_x_ff  <= '0;
         shift_y_ff  <= '0;
         inv_zoom_ff <= 32'd16777216;
         max_iter_ff <= 16'd200;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_START_RE: start_re_ff <= pwdata;
            CSR_START_IM: start_im_ff <= pwdata;
            CSR_SHIFT_X:  shift_x_ff  <= pwdata;
            CSR_SHIFT_Y:  shift_y_ff  <= pwdata;
            CSR_INV_ZOOM: inv_zoom_ff <= pwdata;
            CSR_MAX_ITER: max_iter_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_START_RE: prdata = start_re_ff;
         CSR_START_IM: prdata = start_im_ff;
         CSR_SHIFT_X:  prdata = shift_x_ff;
         CSR_SHIFT_Y:  prdata = shift_y_ff;
         CSR_INV_ZOOM: prdata = inv_zoom_ff;
         CSR_MAX_ITER: prdata = {16'd0, max_iter_ff};
         default:      prdata = '0;
      endcase
   end

   assign iter_cfg.start_re = start_re_ff;
   assign iter_cfg.start_im = start_im_ff;
   assign iter_cfg.max_iter = max_iter_ff;

   etf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_col    (req_col),
      .req_row    (req_row),
      .shift_x    (shift_x_ff),
      .shift_y    (shift_y_ff),
      .inv_zoom   (inv_zoom_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   etf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_data  (pop_data)
   );

   etf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (iter_cfg),
      .queue_empty     (queue_empty),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_iter_count  (rsp_iter_count),
      .rsp_color_class (rsp_color_class)
   );

endmodule

`default_nettype wire

// ===== rtl/core/etf_front.sv =====
// Front end: takes a pixel, pans and maps it, scales by the reciprocal zoom.
// Depends on etf_pkg; pushes the point c into etf_queue.
`default_nettype none

module etf_front import etf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [9:0]         req_col,
   input  logic [9:0]         req_row,
   input  logic signed [31:0] shift_x,
   input  logic signed [31:0] shift_y,
   input  logic [31:0]        inv_zoom,
   input  logic               queue_full,
   output logic               push,
   output point_type          push_data
);

   front_state_type state_ff, state_in;

   logic signed [33:0] px_ff, py_ff;
   logic signed [63:0] ux_ff, uy_ff;
   logic signed [65:0] prod_ff;
   logic [63:0]        plo_ff;
   logic signed [31:0] cre_ff, cim_ff;
   logic               axis_ff;

   logic signed [33:0] px_new, py_new;
   logic signed [63:0] ux_new, uy_new;
   logic signed [63:0] oper;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic signed [97:0] full_prod, scaled;
   logic signed [31:0] c_sat;

   logic accept, do_map, do_lo, do_hi, do_sum;

   // Pan: pixel index in Q16.16 plus the shift.
   assign px_new = $signed({8'd0, req_col, 16'd0}) + 34'(shift_x);
   assign py_new = $signed({8'd0, req_row, 16'd0}) + 34'(shift_y);

   assign ux_new = ((64'(px_ff) * MAP_X_GAIN) >>> SPAN_LOG2) - TWO_POINT_EIGHT_Q32;
   assign uy_new = ((64'(py_ff) * MAP_Y_GAIN) >>> SPAN_LOG2) - ONE_Q32;

   // One shared 33x33 multiplier: low half unsigned, high half signed.
   assign oper  = axis_ff ? uy_ff : ux_ff;
   assign mul_a = (state_ff == F_MUL_LO) ? $signed({1'b0, oper[31:0]})
                                         : 33'($signed(oper[63:32]));
   assign mul_b = $signed({1'b0, inv_zoom});
   assign mul_p = 66'(mul_a) * 66'(mul_b);

   assign full_prod = $signed({prod_ff, 32'd0}) + $signed({34'd0, plo_ff});
   assign scaled    = full_prod >>> ZOOM_SHIFT;

   always_comb begin
      if (scaled > 98'(SAT_MAX)) begin
         c_sat = SAT_MAX;
      end else if (scaled < 98'(SAT_MIN)) begin
         c_sat = SAT_MIN;
      end else begin
         c_sat = scaled[31:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE:   if (req_valid) state_in = F_MAP;
         F_MAP:    state_in = F_MUL_LO;
         F_MUL_LO: state_in = F_MUL_HI;
         F_MUL_HI: state_in = F_SUM;
         F_SUM:    state_in = axis_ff ? F_PUSH : F_MUL_LO;
         F_PUSH:   if (!queue_full) state_in = F_IDLE;
         default:  state_in = F_IDLE;
      endcase
   end

   // Outputs and datapath enables.
   always_comb begin
      req_stall = 1'b1;
      push      = 1'b0;
      accept    = 1'b0;
      do_map    = 1'b0;
      do_lo     = 1'b0;
      do_hi     = 1'b0;
      do_sum    = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         F_MAP:    do_map = 1'b1;
         F_MUL_LO: do_lo  = 1'b1;
         F_MUL_HI: do_hi  = 1'b1;
         F_SUM:    do_sum = 1'b1;
         F_PUSH:   push   = !queue_full;
         default: ;
      endcase
   end

   assign push_data.c_re = cre_ff;
   assign push_data.c_im = cim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            axis_ff <= 1'b0;
         end else if (do_sum) begin
            axis_ff <= !axis_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff <= px_new;
         py_ff <= py_new;
      end
      if (do_map) begin
         ux_ff <= ux_new;
         uy_ff <= uy_new;
      end
      if (do_lo) begin
         plo_ff <= mul_p[63:0];
      end
      if (do_hi) begin
         prod_ff <= mul_p;
      end
      if (do_sum) begin
         if (axis_ff) begin
            cim_ff <= c_sat;
         end else begin
            cre_ff <= c_sat;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/etf_queue.sv =====
// Two-entry queue of mapped points between front and back end.
// Depends on etf_pkg for point_type and the depth.
`default_nettype none

module etf_queue import etf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  point_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output point_type pop_data
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   point_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/etf_back.sv =====
// Back end: iterates z = z*z + c for one point, classifies the count.
// Depends on etf_pkg; pulls points from etf_queue, drives the result channel.
`default_nettype none

module etf_back import etf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  iter_cfg_type cfg,
   input  logic         queue_empty,
   input  point_type    pop_data,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [15:0]  rsp_iter_count,
   output logic [3:0]   rsp_color_class
);

   back_state_type state_ff, state_in;

   logic signed [31:0] zr_ff, zi_ff, cre_ff, cim_ff;
   logic signed [63:0] rr_ff, ii_ff, ri_ff;
   logic [15:0]        iter_ff;
   logic [3:0]         digit_ff, pal_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_iter_ff;
   logic [3:0]         rsp_class_ff;

   logic               limit_hit, escape;
   logic [64:0]        mag;
   logic signed [64:0] diff;
   logic signed [65:0] nr_wide, ni_wide;
   logic signed [31:0] nr_sat, ni_sat;
   logic [3:0]         cls;
   logic               do_mul, do_step, load_out;

   assign limit_hit = (iter_ff >= cfg.max_iter);
   assign mag       = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign escape    = (mag > ESC_LIMIT);

   assign diff    = 65'(rr_ff) - 65'(ii_ff);
   assign nr_wide = 66'(diff >>> FRAC_BITS) + 66'(cre_ff);
   assign ni_wide = 66'(ri_ff >>> (FRAC_BITS - 1)) + 66'(cim_ff);

   always_comb begin
      if (nr_wide > 66'(SAT_MAX)) begin
         nr_sat = SAT_MAX;
      end else if (nr_wide < 66'(SAT_MIN)) begin
         nr_sat = SAT_MIN;
      end else begin
         nr_sat = nr_wide[31:0];
      end
      if (ni_wide > 66'(SAT_MAX)) begin
         ni_sat = SAT_MAX;
      end else if (ni_wide < 66'(SAT_MIN)) begin
         ni_sat = SAT_MIN;
      end else begin
         ni_sat = ni_wide[31:0];
      end
   end

   // Black wins over inside; otherwise the running palette index.
   always_comb begin
      if (iter_ff < BLACK_LIMIT) begin
         cls = COLOR_BLACK;
      end else if (iter_ff == cfg.max_iter) begin
         cls = COLOR_INSIDE;
      end else begin
         cls = pal_ff + 4'd1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (!queue_empty) state_in = B_MUL;
         B_MUL:   state_in = limit_hit ? B_DONE : B_STEP;
         B_STEP:  state_in = escape ? B_DONE : B_MUL;
         B_DONE:  if (!rsp_valid_ff || !rsp_stall) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Outputs and datapath enables.
   always_comb begin
      pop      = 1'b0;
      do_mul   = 1'b0;
      do_step  = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         B_IDLE:  pop      = !queue_empty;
         B_MUL:   do_mul   = !limit_hit;
         B_STEP:  do_step  = !escape;
         B_DONE:  load_out = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign rsp_valid_in    = load_out || (rsp_valid_ff && rsp_stall);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_iter_count  = rsp_iter_ff;
   assign rsp_color_class = rsp_class_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cre_ff   <= pop_data.c_re;
         cim_ff   <= pop_data.c_im;
         zr_ff    <= cfg.start_re;
         zi_ff    <= cfg.start_im;
         iter_ff  <= '0;
         digit_ff <= '0;
         pal_ff   <= '0;
      end
      if (do_mul) begin
         rr_ff <= 64'(zr_ff) * 64'(zr_ff);
         ii_ff <= 64'(zi_ff) * 64'(zi_ff);
         ri_ff <= 64'(zr_ff) * 64'(zi_ff);
      end
      if (do_step) begin
         zr_ff   <= nr_sat;
         zi_ff   <= ni_sat;
         iter_ff <= iter_ff + 16'd1;
         // Track (count / 10) % 9 alongside the count.
         if (digit_ff == DIGIT_LAST) begin
            digit_ff <= '0;
            pal_ff   <= (pal_ff == PALETTE_LAST) ? 4'd0 : pal_ff + 4'd1;
         end else begin
            digit_ff <= digit_ff + 4'd1;
         end
      end
      if (load_out) begin
         rsp_iter_ff  <= iter_ff;
         rsp_class_ff <= cls;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/etf_checker.sv =====
// Port-level checks on the escape-time fractal pixel engine, bound to the top.
// Depends on etf_pkg and escape_time_fractal_pixel_top.
`default_nettype none

module etf_checker import etf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_iter_count,
   input logic [3:0]  rsp_color_class
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_iter_count)
                                 && $stable(rsp_color_class))
      else $error("stalled result changed");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_color_class <= COLOR_INSIDE)
      else $error("color class out of range");

   // Black exactly for short counts.
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_iter_count < BLACK_LIMIT) == (rsp_color_class == COLOR_BLACK)))
      else $error("black class does not match count");

   // A transfer in closes the request channel while the pixel is mapped.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

   // Check the first edge after reset is released.
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind escape_time_fractal_pixel_top etf_checker u_etf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_iter_count  (rsp_iter_count),
   .rsp_color_class (rsp_color_class)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for escape_time_fractal_pixel_top: pixel transfers in, escape counts out.
// Depends on etf_pkg and the RTL under rtl/core; nothing else is read or required.

module tb_top;
   import etf_pkg::*;

   localparam int unsigned RANDOM_PHASES   = 16;
   localparam int unsigned ITEMS_PER_PHASE = 125;
   localparam int unsigned LONG_HOLD       = 600;
   localparam int unsigned CSR_UNUSED      = 6;
   localparam int unsigned BLACK_BELOW     = 5;
   localparam logic signed [63:0] RE_OFFSET_Q32 = 64'sd12025908429;
   localparam logic signed [63:0] IM_OFFSET_Q32 = 64'sd4294967296;
   localparam logic [63:0] ESCAPE_BOUND =
      (2 * FRAC_BITS + 2 < 64) ? (64'd1 << (2 * FRAC_BITS + 2)) : {64{1'b1}};

   typedef struct packed {
      logic [9:0] col;
      logic [9:0] row;
   } pixel_req_type;

   typedef struct packed {
      logic [9:0]  col;
      logic [9:0]  row;
      logic [15:0] iter_count;
      logic [3:0]  color_class;
   } pixel_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [9:0]        req_col = '0;
   logic [9:0]        req_row = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [15:0]       rsp_iter_count;
   logic [3:0]        rsp_color_class;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   // Register shadow, written only while the engine is idle.
   logic signed [31:0] cfg_start_re = 0;
   logic signed [31:0] cfg_start_im = 0;
   logic signed [31:0] cfg_shift_x  = 0;
   logic signed [31:0] cfg_shift_y  = 0;
   logic [31:0]        cfg_inv_zoom = 32'd16777216;
   logic [15:0]        cfg_max_iter = 16'd200;

   // Engine state after the last pixel.
   logic signed [31:0] last_z_re, last_z_im, last_c_re, last_c_im;
   logic [15:0]        last_count;

   pixel_req_type    pixels_to_send[$];
   pixel_result_type escape_results_due[$];

   int unsigned error_count = 0;
   int unsigned idle_pct = 0;
   bit          quiet_run = 1'b0;
   bit          want_long_hold = 1'b0;
   bit          long_hold_done = 1'b0;
   int unsigned send_gap = 0;
   int unsigned drain_gap = 0;
   int unsigned long_hold_left = 0;

   escape_time_fractal_pixel_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_col(req_col),
      .req_row(req_row),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_iter_count(rsp_iter_count),
      .rsp_color_class(rsp_color_class),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #6 clock = ~clock;

   function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < SAT_MIN) return SAT_MIN;
      return v[31:0];
   endfunction

   // floor(u * zoom / 2^ZOOM_SHIFT), u in Q.32 and zoom in Q8.24
   function automatic logic signed [31:0] scale_by_zoom(logic signed [63:0] u,
                                                        logic [31:0] zoom);
      logic signed [127:0] wide_u;
      logic signed [127:0] wide_z;
      wide_u = 128'(u);
      wide_z = {96'd0, zoom};
      return clamp32((wide_u * wide_z) >>> ZOOM_SHIFT);
   endfunction

   function automatic pixel_result_type compute_escape(logic [9:0] col, logic [9:0] row);
      logic signed [63:0] px, py, ux, uy;
      logic signed [63:0] zr, zi, rr, ii, ri;
      logic [63:0]        mag;
      int unsigned        n;
      pixel_result_type   res;
      px = $signed({54'd0, col}) * 64'sd65536 + 64'(cfg_shift_x);
      py = $signed({54'd0, row}) * 64'sd65536 + 64'(cfg_shift_y);
      ux = ((px * 64'sd262144) >>> $clog2(SPAN)) - RE_OFFSET_Q32;
      uy = ((py * 64'sd229376) >>> $clog2(SPAN)) - IM_OFFSET_Q32;
      last_c_re = scale_by_zoom(ux, cfg_inv_zoom);
      last_c_im = scale_by_zoom(uy, cfg_inv_zoom);
      zr = 64'(cfg_start_re);
      zi = 64'(cfg_start_im);
      n = 0;
      while (n < cfg_max_iter) begin
         rr = zr * zr;
         ii = zi * zi;
         ri = zr * zi;
         mag = rr + ii;
         if (mag > ESCAPE_BOUND) break;
         zr = 64'(clamp32(128'(((rr - ii) >>> FRAC_BITS) + last_c_re)));
         zi = 64'(clamp32(128'((ri >>> (FRAC_BITS - 1)) + last_c_im)));
         n++;
      end
      last_z_re = zr[31:0];
      last_z_im = zi[31:0];
      last_count = n[15:0];
      res.col = col;
      res.row = row;
      res.iter_count = n[15:0];
      if (n < BLACK_BELOW) res.color_class = COLOR_BLACK;
      else if (n == cfg_max_iter) res.color_class = COLOR_INSIDE;
      else res.color_class = 4'(1 + (n / 10) % 9);
      return res;
   endfunction

   // Mostly small values around zero, sometimes exactly zero or anything at all.
   function automatic logic [31:0] random_offset(int unsigned half);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 20) return 32'd0;
      if (roll < 85) return 32'($urandom_range(2 * half)) - 32'(half);
      return $urandom();
   endfunction

   task automatic csr_write(int unsigned index, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_AW'(index * 4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         CSR_START_RE: cfg_start_re = value;
         CSR_START_IM: cfg_start_im = value;
         CSR_SHIFT_X:  cfg_shift_x = value;
         CSR_SHIFT_Y:  cfg_shift_y = value;
         CSR_INV_ZOOM: cfg_inv_zoom = value;
         CSR_MAX_ITER: cfg_max_iter = value[15:0];
         default: ;
      endcase
   endtask

   task automatic queue_pixel(logic [9:0] col, logic [9:0] row);
      pixel_req_type item;
      item.col = col;
      item.row = row;
      pixels_to_send.push_back(item);
   endtask

   task automatic wait_drained();
      while (pixels_to_send.size() != 0 || req_valid || escape_results_due.size() != 0)
         @(posedge clock);
   endtask

   // Driver: offer queued pixels, with idle bursts between transfers.
   always @(posedge clock) begin : drive_pixels
      pixel_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            escape_results_due.push_back(compute_escape(req_col, req_row));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet_run && $urandom_range(99) < idle_pct) begin
               send_gap = $urandom_range(16);
               req_valid <= 1'b0;
            end else if (pixels_to_send.size() != 0) begin
               nxt = pixels_to_send.pop_front();
               req_valid <= 1'b1;
               req_col <= nxt.col;
               req_row <= nxt.row;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure: one long hold on request, otherwise random bursts.
   always @(posedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_stall <= 1'b1;
      end else if (want_long_hold && !long_hold_done) begin
         long_hold_done = 1'b1;
         long_hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (drain_gap > 0) begin
         drain_gap--;
         rsp_stall <= 1'b1;
      end else if (!quiet_run && $urandom_range(99) < idle_pct) begin
         drain_gap = $urandom_range(16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare each result transfer with the oldest prediction.
   always @(posedge clock) begin : check_results
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (escape_results_due.size() == 0) begin
            $display("%0t: unexpected result iter_count=%0d color_class=%0d",
                     $time, rsp_iter_count, rsp_color_class);
            error_count++;
         end else begin
            want = escape_results_due.pop_front();
            if (rsp_iter_count !== want.iter_count) begin
               $display("%0t: pixel (%0d,%0d) iter_count expected %0d actual %0d",
                        $time, want.col, want.row, want.iter_count, rsp_iter_count);
               error_count++;
            end
            if (rsp_color_class !== want.color_class) begin
               $display("%0t: pixel (%0d,%0d) color_class expected %0d actual %0d",
                        $time, want.col, want.row, want.color_class, rsp_color_class);
               error_count++;
            end
         end
      end
   end

   // The slowest correct run ends well inside this timeout even with every
   // pixel at its limit and every stall at its longest.
   initial begin
      #100_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned roll;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: corners of the pixel range and a point in the cardioid.
      queue_pixel(10'd0, 10'd0);
      queue_pixel(10'd1023, 10'd1023);
      queue_pixel(10'd0, 10'd1023);
      queue_pixel(10'd1023, 10'd0);
      queue_pixel(10'd166, 10'd73);
      queue_pixel(10'd128, 10'd128);
      queue_pixel(10'd85, 10'd170);
      wait_drained();

      // Low counts stay black even when the limit is reached.
      csr_write(CSR_MAX_ITER, 32'd3);
      queue_pixel(10'd166, 10'd73);
      wait_drained();
      csr_write(CSR_MAX_ITER, 32'd5);
      queue_pixel(10'd166, 10'd73);
      wait_drained();
      // Zero limit: no iteration at all.
      csr_write(CSR_MAX_ITER, 32'd0);
      queue_pixel(10'd166, 10'd73);
      wait_drained();

      // Zero zoom pins c to the origin; run the largest limit once.
      csr_write(CSR_INV_ZOOM, 32'd0);
      csr_write(CSR_MAX_ITER, 32'h0000_FFFF);
      queue_pixel(10'd512, 10'd512);
      wait_drained();

      // Start point outside the escape radius, then exactly on it.
      csr_write(CSR_START_RE, 32'h7FFF_FFFF);
      csr_write(CSR_START_IM, 32'h8000_0000);
      queue_pixel(10'd5, 10'd5);
      wait_drained();
      csr_write(CSR_START_RE, 32'h1000_0000);
      csr_write(CSR_START_IM, 32'd0);
      csr_write(CSR_UNUSED, 32'hFFFF_FFFF);
      queue_pixel(10'd300, 10'd700);
      wait_drained();

      // Saturate c with extreme pans and the largest zoom factor.
      csr_write(CSR_START_RE, 32'd0);
      csr_write(CSR_SHIFT_X, 32'h7FFF_FFFF);
      csr_write(CSR_SHIFT_Y, 32'h8000_0000);
      csr_write(CSR_INV_ZOOM, 32'hFFFF_FFFF);
      csr_write(CSR_MAX_ITER, 32'd1);
      queue_pixel(10'd0, 10'd0);
      queue_pixel(10'd1023, 10'd1023);
      wait_drained();
      csr_write(CSR_SHIFT_X, 32'h8000_0000);
      csr_write(CSR_SHIFT_Y, 32'h7FFF_FFFF);
      csr_write(CSR_INV_ZOOM, 32'd1);
      csr_write(CSR_MAX_ITER, 32'd200);
      queue_pixel(10'd1023, 10'd0);
      queue_pixel(10'd0, 10'd1023);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         quiet_run = (phase >= RANDOM_PHASES - 2);
         idle_pct = quiet_run ? 0 : $urandom_range(2) * 20;
         csr_write(CSR_START_RE, random_offset(32'h0400_0000));
         csr_write(CSR_START_IM, random_offset(32'h0400_0000));
         csr_write(CSR_SHIFT_X, random_offset(32'h0040_0000));
         csr_write(CSR_SHIFT_Y, random_offset(32'h0040_0000));
         roll = $urandom_range(99);
         if (roll < 40) csr_write(CSR_INV_ZOOM, 32'h0100_0000);
         else if (roll < 85) csr_write(CSR_INV_ZOOM, $urandom_range(32'h0200_0000, 32'h0040_0000));
         else if (roll < 93) csr_write(CSR_INV_ZOOM, $urandom_range(32'h0010_0000, 1));
         else csr_write(CSR_INV_ZOOM, $urandom());
         case ($urandom_range(3))
            0: csr_write(CSR_MAX_ITER, $urandom_range(16, 1));
            1: csr_write(CSR_MAX_ITER, $urandom_range(64, 5));
            2: csr_write(CSR_MAX_ITER, $urandom_range(255, 1));
            default: csr_write(CSR_MAX_ITER, 32'd200);
         endcase
         // Short limits and a stalled receiver: fill the engine and back up the input.
         if (phase == 2) begin
            csr_write(CSR_MAX_ITER, $urandom_range(16, 1));
            idle_pct = 0;
            want_long_hold = 1'b1;
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if ($urandom_range(99) < 75)
               queue_pixel(10'($urandom_range(255)), 10'($urandom_range(255)));
            else
               queue_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0 && escape_results_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
